>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checkers; clock and reset are implicit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, skipped while in reset.
`define CHK_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Same, with the consequent checked in the next cycle.
`define CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/cfft_pkg.sv
// ----------------------------------------------------------------------------
// cfft_pkg
// Types, constants and the twiddle generator of the centered FFT frame core.
// ----------------------------------------------------------------------------
package cfft_pkg;

   localparam int POINTS_DEF = 256;
   localparam int DATA_W     = 32;   // butterfly word per component
   localparam int TW_W       = 17;   // twiddle / scale operand, signed
   localparam int PROD_W     = DATA_W + TW_W;
   localparam int ACC_W      = PROD_W + 1;
   localparam int SCALE_ODD  = 23170; // 1/sqrt(2), Q1.15
   localparam int SCALE_EVEN = 32768; // 1.0, Q1.15

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RDA,
      S_RDB,
      S_LATB,
      S_M0,
      S_M1,
      S_M2,
      S_M3,
      S_SUM,
      S_WR0,
      S_WR1,
      S_SC_RD,
      S_SC_M0,
      S_SC_M1,
      S_SC_WR
   } state_type;

   // cos(2*pi*t/2^lg) in Q1.15 through a Q30 Taylor series; elaboration only.
   function automatic logic [15:0] cos_q15(input int unsigned t, input int unsigned lg);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        q;
      logic signed [63:0] sum;
      logic [63:0]        r;
      x    = (PI_Q30 * 64'd2 * 64'(t) + (64'd1 << (lg - 1))) >> lg;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = $signed(term);
      for (int k = 1; k <= 10; k++) begin
         q = (term * x2) >> 30;
         unique case (k)
            1:       term = q / 2;
            2:       term = q / 12;
            3:       term = q / 30;
            4:       term = q / 56;
            5:       term = q / 90;
            6:       term = q / 132;
            7:       term = q / 182;
            8:       term = q / 240;
            9:       term = q / 306;
            default: term = q / 380;
         endcase
         if (k % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum <= 0) begin
         return 16'd0;
      end
      r = (64'(sum) + 64'd16384) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[15:0];
   endfunction

endpackage

>>> design/cfft_ram.sv
// ----------------------------------------------------------------------------
// cfft_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cfft_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/centered_fft_ifft_frame_core.sv
// ----------------------------------------------------------------------------
// centered_fft_ifft_frame_core
// Frame FFT / IFFT with centered spectrum order, one shared butterfly unit.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel (valid/stall) brings one complex sample per item. Samples
//    fill a frame of N = 2^floor(log2(POINTS)) positions.
//  - rsp_ channel (valid/stall) returns one item per input item: the sample
//    at the same position of the previously transformed frame, plus
//    out_valid (a frame was transformed) and frame_end (last position).
//    Before the first frame completes, the result is zero with out_valid 0.
//  - csr_ write channel sets the direction bit (0 forward, centered output;
//    1 inverse from centered input). Always ready; write it while idle.
//    The value held when a frame's last sample is taken decides that frame.
//  - Flow: a result is registered as its item is taken. Within a frame
//    items are never taken back to back: the index steps and the result
//    memory is read before the next item. The last item of a frame starts
//    the transform: log2(N) stages of N/2 butterflies through the single
//    multiplier, then a scaling pass over every point; no item is taken
//    until the block is idle again.
//  - A stalled result holds the output register; a new item is taken only
//    once the register is free or draining in the same cycle.
//  - Reset (synchronous) clears the frame position, the direction bit and
//    the result-valid flag; memories are not cleared.
// ----------------------------------------------------------------------------
module centered_fft_ifft_frame_core
   import cfft_pkg::*;
#(
   parameter int POINTS = POINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // sample input
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample_re,
   input  logic signed [15:0] req_sample_im,
   // result output
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_re,
   output logic signed [15:0] rsp_out_im,
   output logic               rsp_out_valid,
   output logic               rsp_frame_end,
   // direction register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_direction
);

   localparam int LOG   = $clog2(POINTS + 1) - 1;
   localparam int N     = 1 << LOG;
   localparam int HALF  = N / 2;
   localparam int QUART = N / 4;
   localparam int AW    = LOG;
   localparam int QW    = LOG - 1;
   localparam int SW    = $clog2(LOG);
   localparam int SH    = 15 + LOG / 2;
   localparam int SCALE = (LOG % 2 == 1) ? SCALE_ODD : SCALE_EVEN;

   // twiddle quarter-wave table, elaboration constants
   logic [15:0] cos_tab [QUART+1];
   for (genvar g = 0; g <= QUART; g++) begin : g_tab
      assign cos_tab[g] = cos_q15(g, LOG);
   end

   // control state
   state_type       state_ff, state_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [SW-1:0]   s_ff, s_in;
   logic [AW-2:0]   j_ff, j_in;
   logic [AW-1:0]   e_ff, e_in;
   logic            inverse_ff, inverse_in;
   logic            direction_ff, direction_in;
   logic            ready_ff, ready_in;
   logic            pf_ok_ff, pf_ok_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic signed [DATA_W-1:0] a_re_ff, a_im_ff, b_re_ff, b_im_ff;
   logic signed [TW_W-1:0]   wr_ff, wi_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  accr_ff, acci_ff;
   logic signed [DATA_W-1:0] pr_ff, pim_ff, sc_im_ff;
   logic signed [15:0]       vr_ff;
   logic signed [15:0]       out_re_ff, out_im_ff;
   logic                     out_valid_ff, frame_end_ff;

   logic accept;
   logic last_pos;

   assign accept    = req_valid && !req_stall;
   assign last_pos  = (idx_ff == AW'(N - 1));
   assign req_stall = !((state_ff == S_IDLE) && pf_ok_ff && (!rsp_valid_ff || !rsp_stall));
   assign csr_ready = 1'b1;

   // butterfly addressing: stage s, butterfly j
   logic [AW-1:0] j_ext, addr_a, addr_b, jh, kk, addr1, addr2, tt;
   logic [AW-1:0] tix1, tix2;
   logic [SW:0]   s_p1;
   logic          stage0, last_stage, t_low;

   assign j_ext      = {1'b0, j_ff};
   assign addr_a     = j_ext;
   assign addr_b     = j_ext | AW'(HALF);
   assign jh         = AW'(1) << s_ff;
   assign kk         = j_ext & (jh - AW'(1));
   assign s_p1       = {1'b0, s_ff} + (SW+1)'(1);
   assign addr1      = ((j_ext >> s_ff) << s_p1) | kk;
   assign addr2      = addr1 | jh;
   assign tt         = kk << ((SW+1)'(AW - 1) - {1'b0, s_ff});
   assign stage0     = (s_ff == '0);
   assign last_stage = (s_ff == SW'(LOG - 1));
   assign t_low      = (tt <= AW'(QUART));
   assign tix1       = t_low ? tt : (AW'(HALF) - tt);
   assign tix2       = t_low ? (AW'(QUART) - tt) : (tt - AW'(QUART));

   // twiddle with direction signs
   logic signed [TW_W-1:0] c1, c2, wr0, wi0, wr_n, wi_n;
   assign c1  = $signed({1'b0, cos_tab[tix1[QW-1:0]]});
   assign c2  = $signed({1'b0, cos_tab[tix2[QW-1:0]]});
   assign wr0 = t_low ? c1 : -c1;
   assign wi0 = c2;
   always_comb begin
      if (inverse_ff) begin
         wr_n = wr0;
         wi_n = wi0;
      end else if (last_stage) begin
         wr_n = -wr0;
         wi_n = wi0;
      end else begin
         wr_n = wr0;
         wi_n = -wi0;
      end
   end

   // memory read side
   logic [AW-1:0]          rd_addr;
   logic [31:0]            in_rd, res_rd;
   logic [2*DATA_W-1:0]    w0_rd, w1_rd, src_rd, w_wdata;
   logic                   sc_phase, w_sel;
   logic signed [DATA_W-1:0] rd_re, rd_im;

   always_comb begin
      unique case (state_ff)
         S_RDA:   rd_addr = (inverse_ff && stage0) ? addr_b : addr_a;
         S_RDB:   rd_addr = (inverse_ff && stage0) ? addr_a : addr_b;
         default: rd_addr = e_ff;
      endcase
   end

   assign sc_phase = (state_ff == S_SC_M0);
   assign w_sel    = sc_phase ? s_ff[0] : ~s_ff[0];

   always_comb begin
      if (stage0 && !sc_phase) begin
         src_rd = {DATA_W'($signed(in_rd[31:16])), DATA_W'($signed(in_rd[15:0]))};
      end else begin
         src_rd = w_sel ? w1_rd : w0_rd;
      end
   end
   assign rd_re = $signed(src_rd[DATA_W-1:0]);
   assign rd_im = $signed(src_rd[2*DATA_W-1:DATA_W]);

   // shared multiplier
   logic signed [DATA_W-1:0] mul_a;
   logic signed [TW_W-1:0]   mul_b;
   always_comb begin
      unique case (state_ff)
         S_M1:    begin mul_a = b_im_ff;  mul_b = wi_ff; end
         S_M2:    begin mul_a = b_re_ff;  mul_b = wi_ff; end
         S_M3:    begin mul_a = b_im_ff;  mul_b = wr_ff; end
         S_SC_M0: begin mul_a = rd_re;    mul_b = TW_W'(SCALE); end
         S_SC_M1: begin mul_a = sc_im_ff; mul_b = TW_W'(SCALE); end
         default: begin mul_a = b_re_ff;  mul_b = wr_ff; end
      endcase
   end

   // product rounding
   logic signed [ACC_W:0]    r15_r, r15_i;
   logic signed [DATA_W-1:0] pr_c, pim_c;
   assign r15_r = ({accr_ff[ACC_W-1], accr_ff} + (ACC_W+1)'(16384)) >>> 15;
   assign r15_i = ({acci_ff[ACC_W-1], acci_ff} + (ACC_W+1)'(16384)) >>> 15;
   assign pr_c  = r15_r[DATA_W-1:0];
   assign pim_c = r15_i[DATA_W-1:0];

   // final scale and saturation; arithmetic shift keeps the sign
   logic signed [ACC_W-1:0] sc_r;
   logic signed [15:0]      sc_sat;
   assign sc_r = $signed({prod_ff[PROD_W-1], prod_ff} + (ACC_W'(1) <<< (SH - 1))) >>> SH;
   always_comb begin
      if (sc_r > ACC_W'(32767)) begin
         sc_sat = 16'sh7FFF;
      end else if (sc_r < -ACC_W'(32768)) begin
         sc_sat = -16'sh8000;
      end else begin
         sc_sat = sc_r[15:0];
      end
   end

   // butterfly write data
   always_comb begin
      if (state_ff == S_WR0) begin
         w_wdata = {a_im_ff + pim_c, a_re_ff + pr_c};
      end else begin
         w_wdata = {a_im_ff - pim_ff, a_re_ff - pr_ff};
      end
   end

   logic          w_we, w0_we, w1_we;
   logic [AW-1:0] w_waddr;
   assign w_we    = (state_ff == S_WR0) || (state_ff == S_WR1);
   assign w0_we   = w_we && !s_ff[0];
   assign w1_we   = w_we && s_ff[0];
   assign w_waddr = (state_ff == S_WR0) ? addr1 : addr2;

   cfft_ram #(.WIDTH(32), .DEPTH(N)) u_in_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (idx_ff),
      .wr_data ({req_sample_im, req_sample_re}),
      .rd_addr (rd_addr),
      .rd_data (in_rd)
   );

   cfft_ram #(.WIDTH(2*DATA_W), .DEPTH(N)) u_w0_ram (
      .clock   (clock),
      .wr_en   (w0_we),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_addr (rd_addr),
      .rd_data (w0_rd)
   );

   cfft_ram #(.WIDTH(2*DATA_W), .DEPTH(N)) u_w1_ram (
      .clock   (clock),
      .wr_en   (w1_we),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_addr (rd_addr),
      .rd_data (w1_rd)
   );

   cfft_ram #(.WIDTH(32), .DEPTH(N)) u_res_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_SC_WR),
      .wr_addr (e_ff),
      .wr_data ({sc_sat, vr_ff}),
      .rd_addr (idx_ff),
      .rd_data (res_rd)
   );

   // sequencer: next state and control
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      s_in         = s_ff;
      j_in         = j_ff;
      e_in         = e_ff;
      inverse_in   = inverse_ff;
      ready_in     = ready_ff;
      direction_in = (csr_valid && csr_ready) ? csr_direction : direction_ff;
      pf_ok_in     = (state_ff == S_IDLE) && !accept;
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_stall ? 1'b0 : rsp_valid_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (last_pos) begin
                  idx_in     = '0;
                  s_in       = '0;
                  j_in       = '0;
                  inverse_in = direction_ff;
                  state_in   = S_RDA;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         S_RDA:  state_in = S_RDB;
         S_RDB:  state_in = S_LATB;
         S_LATB: state_in = S_M0;
         S_M0:   state_in = S_M1;
         S_M1:   state_in = S_M2;
         S_M2:   state_in = S_M3;
         S_M3:   state_in = S_SUM;
         S_SUM:  state_in = S_WR0;
         S_WR0:  state_in = S_WR1;
         S_WR1: begin
            if (j_ff == (AW-1)'(HALF - 1)) begin
               j_in = '0;
               if (last_stage) begin
                  e_in     = '0;
                  state_in = S_SC_RD;
               end else begin
                  s_in     = s_ff + SW'(1);
                  state_in = S_RDA;
               end
            end else begin
               j_in     = j_ff + (AW-1)'(1);
               state_in = S_RDA;
            end
         end
         S_SC_RD: state_in = S_SC_M0;
         S_SC_M0: state_in = S_SC_M1;
         S_SC_M1: state_in = S_SC_WR;
         S_SC_WR: begin
            if (e_ff == AW'(N - 1)) begin
               ready_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               e_in     = e_ff + AW'(1);
               state_in = S_SC_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         s_ff         <= '0;
         j_ff         <= '0;
         e_ff         <= '0;
         inverse_ff   <= 1'b0;
         direction_ff <= 1'b0;
         ready_ff     <= 1'b0;
         pf_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         s_ff         <= s_in;
         j_ff         <= j_in;
         e_ff         <= e_in;
         inverse_ff   <= inverse_in;
         direction_ff <= direction_in;
         ready_ff     <= ready_in;
         pf_ok_ff     <= pf_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (state_ff)
         S_RDA: begin
            wr_ff <= wr_n;
            wi_ff <= wi_n;
         end
         S_RDB: begin
            a_re_ff <= rd_re;
            a_im_ff <= rd_im;
         end
         S_LATB: begin
            b_re_ff <= rd_re;
            b_im_ff <= rd_im;
         end
         S_M1:    accr_ff <= ACC_W'(prod_ff);
         S_M2:    accr_ff <= accr_ff - ACC_W'(prod_ff);
         S_M3:    acci_ff <= ACC_W'(prod_ff);
         S_SUM: begin
            acci_ff <= acci_ff + ACC_W'(prod_ff);
            pr_ff   <= pr_c;
         end
         S_WR0:   pim_ff   <= pim_c;
         S_SC_M0: sc_im_ff <= rd_im;
         S_SC_M1: vr_ff    <= sc_sat;
         default: ;
      endcase
      if (accept) begin
         out_re_ff    <= ready_ff ? $signed(res_rd[15:0]) : 16'sd0;
         out_im_ff    <= ready_ff ? $signed(res_rd[31:16]) : 16'sd0;
         out_valid_ff <= ready_ff;
         frame_end_ff <= last_pos;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_re    = out_re_ff;
   assign rsp_out_im    = out_im_ff;
   assign rsp_out_valid = out_valid_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

>>> design/cfft_checker.sv
// ----------------------------------------------------------------------------
// cfft_checker
// Port-level checks of the centered FFT frame core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfft_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic signed [15:0] req_sample_re,
   input logic signed [15:0] req_sample_im,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_out_re,
   input logic signed [15:0] rsp_out_im,
   input logic               rsp_out_valid,
   input logic               rsp_frame_end,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic               csr_direction
);

   // a stalled result holds
   `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_re) && $stable(rsp_out_im), "stalled result changed")

   // every taken item yields a result next cycle
   `CHK_NEXT(a_rsp_follows, req_valid && !req_stall, rsp_valid, "result missing")

   // items are never taken back to back
   `CHK_NEXT(a_no_b2b, req_valid && !req_stall, req_stall, "back-to-back accept")

   // results before the first frame completes are zero
   `CHK_IMPLY(a_zero_invalid, rsp_valid && !rsp_out_valid,
      rsp_out_re == 16'sd0 && rsp_out_im == 16'sd0, "invalid result not zero")

endmodule

bind centered_fft_ifft_frame_core cfft_checker u_cfft_checker (.*);
